/* rtl/fldc_pkg.sv */
package fldc_pkg;

   // Descriptor header layout
   localparam int HDR_LEN = 6;
   localparam logic [7:0] MAGIC_0 = 8'h54;
   localparam logic [7:0] MAGIC_1 = 8'h50;
   localparam logic [7:0] VERSION = 8'h01;

   // Bits in one occupancy byte
   localparam int FIELD_BITS = 8;

   localparam int DEF_MAX_CODES = 128;
   localparam int DEF_MAX_UNIT_BYTES = 64;

   localparam int STATUS_W = 2;
   localparam int UNIT_OUT_W = 7;
   localparam int COUNT_OUT_W = 8;

   typedef enum logic [STATUS_W-1:0] {
      ST_VALID     = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_OVERLAP   = 2'd2
   } status_type;

   typedef struct packed {
      logic                   valid;
      status_type             status;
      logic [UNIT_OUT_W-1:0]  unit_bytes;
      logic [COUNT_OUT_W-1:0] code_count;
   } result_type;

endpackage

/* rtl/fldc_ram.sv */
module fldc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fldc_core.sv */
module fldc_core #(
   parameter int MAX_CODES      = fldc_pkg::DEF_MAX_CODES,
   parameter int MAX_UNIT_BYTES = fldc_pkg::DEF_MAX_UNIT_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 last_byte,
   output fldc_pkg::result_type result
);

   localparam int POS_CAP = fldc_pkg::HDR_LEN + 3 * MAX_CODES;
   localparam int POS_W   = $clog2(POS_CAP + 2);
   localparam int IDX_W   = (MAX_UNIT_BYTES > 1) ? $clog2(MAX_UNIT_BYTES) : 1;
   localparam int LEN_W   = 18;

   localparam logic [POS_W-1:0] POS_MAGIC_0 = POS_W'(0);
   localparam logic [POS_W-1:0] POS_MAGIC_1 = POS_W'(1);
   localparam logic [POS_W-1:0] POS_VERSION = POS_W'(2);
   localparam logic [POS_W-1:0] POS_UNIT    = POS_W'(3);
   localparam logic [POS_W-1:0] POS_CNT_LO  = POS_W'(4);
   localparam logic [POS_W-1:0] POS_CNT_HI  = POS_W'(5);

   typedef enum logic [1:0] {
      PH_OFFSET,
      PH_SHIFT,
      PH_WIDTH
   } phase_type;

   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [7:0]                unit_ff, unit_in;
   logic [15:0]               count_ff, count_in;
   logic [7:0]                offset_ff, offset_in;
   logic [7:0]                shift_ff, shift_in;
   logic                      hdr_bad_ff, hdr_bad_in;
   fldc_pkg::status_type      code_err_ff, code_err_in;
   phase_type                 phase_ff, phase_in;
   logic [MAX_UNIT_BYTES-1:0] valid_ff, valid_in;
   logic                      occ_valid_ff, occ_valid_in;

   logic                      ram_wr_en;
   logic                      ram_rd_en;
   logic [7:0]                ram_rd_data;

   logic                      off_in_range;
   logic                      code_bad;
   logic [15:0]               mask_wide;
   logic [7:0]                mask;
   logic [7:0]                occ;
   logic                      overlap;
   logic [LEN_W-1:0]          len_expect;
   logic                      fault;
   fldc_pkg::status_type      status;

   // An entry whose valid bit is clear has not been claimed since the last clear.
   assign occ = occ_valid_ff ? ram_rd_data : 8'h00;

   assign off_in_range = {1'b0, in_byte} < 9'(MAX_UNIT_BYTES);

   assign code_bad = (offset_ff >= unit_ff) ||
                     ({1'b0, offset_ff} >= 9'(MAX_UNIT_BYTES)) ||
                     (in_byte == 8'h00) ||
                     ({1'b0, in_byte} > 9'(fldc_pkg::FIELD_BITS)) ||
                     (({1'b0, shift_ff} + {1'b0, in_byte}) > 9'(fldc_pkg::FIELD_BITS));

   // Only used once code_bad is clear, so width is 1 to 8 and shift below 8.
   assign mask_wide = ((16'h0001 << in_byte[3:0]) - 16'h0001) << shift_ff[2:0];
   assign mask      = mask_wide[7:0];
   assign overlap   = |(occ & mask);

   fldc_ram #(
      .WIDTH (fldc_pkg::FIELD_BITS),
      .DEPTH (MAX_UNIT_BYTES)
   ) u_occ_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (offset_ff[IDX_W-1:0]),
      .wr_data (occ | mask),
      .rd_en   (ram_rd_en),
      .rd_addr (in_byte[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      pos_in       = pos_ff;
      unit_in      = unit_ff;
      count_in     = count_ff;
      offset_in    = offset_ff;
      shift_in     = shift_ff;
      hdr_bad_in   = hdr_bad_ff;
      code_err_in  = code_err_ff;
      phase_in     = phase_ff;
      valid_in     = valid_ff;
      occ_valid_in = occ_valid_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      len_expect   = '0;
      fault        = 1'b0;
      status       = fldc_pkg::ST_VALID;
      result       = '0;

      if (accept) begin
         if (pos_ff < POS_W'(POS_CAP)) begin
            case (pos_ff)
               POS_MAGIC_0: begin
                  if (in_byte != fldc_pkg::MAGIC_0) hdr_bad_in = 1'b1;
               end
               POS_MAGIC_1: begin
                  if (in_byte != fldc_pkg::MAGIC_1) hdr_bad_in = 1'b1;
               end
               POS_VERSION: begin
                  if (in_byte != fldc_pkg::VERSION) hdr_bad_in = 1'b1;
               end
               POS_UNIT:   unit_in = in_byte;
               POS_CNT_LO: count_in = {count_ff[15:8], in_byte};
               POS_CNT_HI: count_in = {in_byte, count_ff[7:0]};
               default: begin
                  case (phase_ff)
                     PH_OFFSET: begin
                        // Fetch the occupancy byte now; it is used two items later.
                        offset_in    = in_byte;
                        phase_in     = PH_SHIFT;
                        ram_rd_en    = off_in_range;
                        occ_valid_in = off_in_range ? valid_ff[in_byte[IDX_W-1:0]] : 1'b0;
                     end
                     PH_SHIFT: begin
                        shift_in = in_byte;
                        phase_in = PH_WIDTH;
                     end
                     PH_WIDTH: begin
                        phase_in = PH_OFFSET;
                        if (code_err_ff == fldc_pkg::ST_VALID) begin
                           if (code_bad) begin
                              code_err_in = fldc_pkg::ST_MALFORMED;
                           end else if (overlap) begin
                              code_err_in = fldc_pkg::ST_OVERLAP;
                           end else begin
                              ram_wr_en = 1'b1;
                              valid_in[offset_ff[IDX_W-1:0]] = 1'b1;
                           end
                        end
                     end
                     default: phase_in = PH_OFFSET;
                  endcase
               end
            endcase
         end

         // The position stops one past the longest legal descriptor.
         if (pos_ff <= POS_W'(POS_CAP)) begin
            pos_in = pos_ff + POS_W'(1);
         end

         if (last_byte) begin
            len_expect = LEN_W'(fldc_pkg::HDR_LEN) + {2'b00, count_in} +
                         {1'b0, count_in, 1'b0};
            fault = hdr_bad_in ||
                    (count_in == 16'h0000) ||
                    (count_in > 16'(MAX_CODES)) ||
                    (LEN_W'(pos_in) != len_expect) ||
                    (unit_in == 8'h00) ||
                    ({1'b0, unit_in} > 9'(MAX_UNIT_BYTES));
            status = fault ? fldc_pkg::ST_MALFORMED : code_err_in;

            result.valid      = 1'b1;
            result.status     = status;
            result.unit_bytes = (status == fldc_pkg::ST_VALID) ?
                                unit_in[fldc_pkg::UNIT_OUT_W-1:0] : '0;
            result.code_count = (status == fldc_pkg::ST_VALID) ?
                                count_in[fldc_pkg::COUNT_OUT_W-1:0] : '0;

            pos_in       = '0;
            unit_in      = '0;
            count_in     = '0;
            offset_in    = '0;
            shift_in     = '0;
            hdr_bad_in   = 1'b0;
            code_err_in  = fldc_pkg::ST_VALID;
            phase_in     = PH_OFFSET;
            valid_in     = '0;
            occ_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         unit_ff      <= '0;
         count_ff     <= '0;
         offset_ff    <= '0;
         shift_ff     <= '0;
         hdr_bad_ff   <= 1'b0;
         code_err_ff  <= fldc_pkg::ST_VALID;
         phase_ff     <= PH_OFFSET;
         valid_ff     <= '0;
         occ_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         unit_ff      <= unit_in;
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         shift_ff     <= shift_in;
         hdr_bad_ff   <= hdr_bad_in;
         code_err_ff  <= code_err_in;
         phase_ff     <= phase_in;
         valid_ff     <= valid_in;
         occ_valid_ff <= occ_valid_in;
      end
   end

endmodule

/* rtl/field_layout_descriptor_checker_unit.sv */
// Checks a serialized bit-field layout descriptor taken one byte per item, one item per
// clock cycle while not stalled, and returns a single registered verdict item for the byte
// marked last. Each triplet's occupancy byte is read from a small RAM with registered
// read when its offset byte arrives and written back on its width byte, so consecutive
// triplets never wait on each other; a per-entry valid bit clears the whole map at once
// at reset and after each verdict, so no clearing pass is needed. The result side
// has an output register and a one-deep skid register; input stalls only while both hold
// verdicts that have not been taken.
module field_layout_descriptor_checker_unit #(
   parameter int MAX_CODES      = fldc_pkg::DEF_MAX_CODES,
   parameter int MAX_UNIT_BYTES = fldc_pkg::DEF_MAX_UNIT_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_last_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fldc_pkg::STATUS_W-1:0]    rsp_status,
   output logic [fldc_pkg::UNIT_OUT_W-1:0]  rsp_unit_bytes_out,
   output logic [fldc_pkg::COUNT_OUT_W-1:0] rsp_code_count_out
);

   fldc_pkg::result_type core_res;
   fldc_pkg::result_type out_ff, out_in;
   fldc_pkg::result_type skid_ff, skid_in;
   logic                 req_accept;
   logic                 out_free;

   assign req_stall  = skid_ff.valid;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !out_ff.valid || !rsp_stall;

   fldc_core #(
      .MAX_CODES      (MAX_CODES),
      .MAX_UNIT_BYTES (MAX_UNIT_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .in_byte   (req_in_byte),
      .last_byte (req_last_byte),
      .result    (core_res)
   );

   // No new item is accepted while the skid register is full, so a waiting verdict
   // and a fresh one never compete for the output register.
   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (out_free) begin
         if (skid_ff.valid) begin
            out_in  = skid_ff;
            skid_in = '0;
         end else begin
            out_in = core_res;
         end
      end else if (core_res.valid) begin
         skid_in = core_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff  <= '0;
         skid_ff <= '0;
      end else begin
         out_ff  <= out_in;
         skid_ff <= skid_in;
      end
   end

   assign rsp_valid          = out_ff.valid;
   assign rsp_status         = out_ff.status;
   assign rsp_unit_bytes_out = out_ff.unit_bytes;
   assign rsp_code_count_out = out_ff.code_count;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_ff.valid |-> out_ff.valid)
      else $error("skid register holds a verdict while the output register is empty");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=> rsp_valid)
      else $error("last byte accepted but no verdict presented");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == fldc_pkg::ST_VALID ||
                     rsp_status == fldc_pkg::ST_MALFORMED ||
                     rsp_status == fldc_pkg::ST_OVERLAP))
      else $error("verdict carries an unused status code");

   a_fault_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fldc_pkg::ST_VALID |->
         rsp_unit_bytes_out == '0 && rsp_code_count_out == '0)
      else $error("failing verdict carries a non-zero unit size or code count");

   a_no_result_without_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_accept && req_last_byte) |=> !rsp_valid)
      else $error("verdict appeared without a last byte");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

   localparam int POS_LIMIT = fldc_pkg::HDR_LEN + 3 * fldc_pkg::DEF_MAX_CODES;

   typedef struct {
      fldc_pkg::status_type             st;
      logic [fldc_pkg::UNIT_OUT_W-1:0]  unit;
      logic [fldc_pkg::COUNT_OUT_W-1:0] count;
   } verdict_type;

   // Tracks the descriptor being received and holds the verdicts still to come out.
   class verdict_board;
      int unsigned          byte_pos;
      logic [7:0]           unit_size;
      logic [15:0]          code_total;
      logic [7:0]           cur_offset;
      logic [7:0]           cur_shift;
      bit                   header_fault;
      fldc_pkg::status_type first_fault;
      logic [7:0]           claimed[fldc_pkg::DEF_MAX_UNIT_BYTES];
      verdict_type          waiting[$];
      int                   mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         byte_pos = 0;
         unit_size = '0;
         code_total = '0;
         cur_offset = '0;
         cur_shift = '0;
         header_fault = 1'b0;
         first_fault = fldc_pkg::ST_VALID;
         foreach (claimed[i]) claimed[i] = '0;
      endfunction

      function void judge_field(logic [7:0] wd);
         logic [15:0] span;
         if (first_fault != fldc_pkg::ST_VALID) return;
         if (cur_offset >= unit_size || cur_offset >= fldc_pkg::DEF_MAX_UNIT_BYTES ||
             wd == 0 || wd > fldc_pkg::FIELD_BITS ||
             int'(cur_shift) + int'(wd) > fldc_pkg::FIELD_BITS) begin
            first_fault = fldc_pkg::ST_MALFORMED;
            return;
         end
         span = ((16'd1 << wd) - 16'd1) << cur_shift;
         if ((claimed[cur_offset] & span[7:0]) != 0) begin
            first_fault = fldc_pkg::ST_OVERLAP;
            return;
         end
         claimed[cur_offset] = claimed[cur_offset] | span[7:0];
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         verdict_type v;
         bit          broken;
         if (byte_pos < POS_LIMIT) begin
            case (byte_pos)
               0: if (b != fldc_pkg::MAGIC_0) header_fault = 1'b1;
               1: if (b != fldc_pkg::MAGIC_1) header_fault = 1'b1;
               2: if (b != fldc_pkg::VERSION) header_fault = 1'b1;
               3: unit_size = b;
               4: code_total[7:0] = b;
               5: code_total[15:8] = b;
               default: begin
                  case ((byte_pos - fldc_pkg::HDR_LEN) % 3)
                     0: cur_offset = b;
                     1: cur_shift = b;
                     default: judge_field(b);
                  endcase
               end
            endcase
         end
         if (byte_pos <= POS_LIMIT) byte_pos++;
         if (!last) return;
         broken = header_fault || code_total == 0 || code_total > fldc_pkg::DEF_MAX_CODES ||
                  byte_pos != fldc_pkg::HDR_LEN + 3 * int'(code_total) ||
                  unit_size == 0 || unit_size > fldc_pkg::DEF_MAX_UNIT_BYTES;
         v.st = broken ? fldc_pkg::ST_MALFORMED : first_fault;
         v.unit = (v.st == fldc_pkg::ST_VALID) ? unit_size[fldc_pkg::UNIT_OUT_W-1:0] : '0;
         v.count = (v.st == fldc_pkg::ST_VALID) ? code_total[fldc_pkg::COUNT_OUT_W-1:0] : '0;
         waiting.push_back(v);
         restart();
      endfunction

      function void check_verdict(logic [fldc_pkg::STATUS_W-1:0] st,
                                  logic [fldc_pkg::UNIT_OUT_W-1:0] u,
                                  logic [fldc_pkg::COUNT_OUT_W-1:0] c);
         verdict_type want;
         if (waiting.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected verdict: status %0d unit %0d count %0d", st, u, c);
            return;
         end
         want = waiting.pop_front();
         if (st !== want.st || u !== want.unit || c !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"verdict mismatch: expected status %0d unit %0d count %0d, ",
                         "got %0d %0d %0d"},
                        want.st, want.unit, want.count, st, u, c);
         end
      endfunction

      function int outstanding();
         return waiting.size();
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [7:0]                       req_in_byte;
   logic                             req_last_byte;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [fldc_pkg::STATUS_W-1:0]    rsp_status;
   logic [fldc_pkg::UNIT_OUT_W-1:0]  rsp_unit_bytes_out;
   logic [fldc_pkg::COUNT_OUT_W-1:0] rsp_code_count_out;

   verdict_board board = new();
   logic [7:0]   stream[$];
   int           burst_left = 0;
   bit           hold_off_go = 1'b0;

   field_layout_descriptor_checker_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_unit_bytes_out (rsp_unit_bytes_out),
      .rsp_code_count_out (rsp_code_count_out)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: rotates a stall pattern that is replaced every so often, and honours a
   // request for one long hold-off.
   initial begin
      logic [15:0] pattern;
      int          window;
      int          hold_left;
      pattern = '0;
      window = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            hold_left = 300;
         end
         if (window == 0) begin
            window = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
               0: pattern = '0;
               1: pattern = 16'($urandom) & 16'($urandom);
               2: pattern = 16'($urandom);
               default: pattern = 16'($urandom) | 16'($urandom);
            endcase
         end
         window--;
         pattern = {pattern[14:0], pattern[15]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= pattern[0];
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_verdict(rsp_status, rsp_unit_bytes_out, rsp_code_count_out);
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_in_byte <= 8'($urandom);
            req_last_byte <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      board.note_byte(b, last);
   endtask

   task automatic send_stream();
      int i;
      for (i = 0; i < stream.size(); i++) send_byte(stream[i], i == stream.size() - 1);
      stream.delete();
   endtask

   // Stops offering and waits until every verdict owed has been taken; the wait on the
   // clock comes before the check, so that the next item is driven in a later time step.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   function automatic void add_header(logic [7:0] m0, logic [7:0] m1, logic [7:0] ver,
                                      logic [7:0] unit, logic [15:0] count);
      stream.push_back(m0);
      stream.push_back(m1);
      stream.push_back(ver);
      stream.push_back(unit);
      stream.push_back(count[7:0]);
      stream.push_back(count[15:8]);
   endfunction

   function automatic void good_header(logic [7:0] unit, logic [15:0] count);
      add_header(fldc_pkg::MAGIC_0, fldc_pkg::MAGIC_1, fldc_pkg::VERSION, unit, count);
   endfunction

   function automatic void add_code(logic [7:0] off, logic [7:0] sh, logic [7:0] wd);
      stream.push_back(off);
      stream.push_back(sh);
      stream.push_back(wd);
   endfunction

   // Two fields per byte, low and high nibble, so they never collide.
   function automatic void add_packed_codes(int n);
      int i;
      for (i = 0; i < n; i++) begin
         if (i % 2 == 0)
            add_code(8'(i / 2), 8'd0, 8'($urandom_range(1, 4)));
         else
            add_code(8'(i / 2), 8'd4, 8'($urandom_range(1, 4)));
      end
   endfunction

   function automatic void add_wild_codes(int n, int unit);
      int i;
      for (i = 0; i < n; i++) begin
         add_code(8'($urandom_range(0, unit)),
                  ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
                  ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8)));
      end
   endfunction

   function automatic void add_noise(int n);
      repeat (n) stream.push_back(8'($urandom));
   endfunction

   initial begin
      int kind;
      int n;
      int unit;
      int random_bytes;
      int verdicts;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_in_byte <= '0;
      req_last_byte <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed descriptors. The one with 129 codes also runs past the position limit.
      good_header(8'd1, 16'd1); add_code(8'd0, 8'd0, 8'd8); send_stream();
      good_header(8'd64, 16'd1); add_code(8'd63, 8'd7, 8'd1); send_stream();
      good_header(8'd64, 16'd128); add_packed_codes(128); send_stream();
      good_header(8'd64, 16'd129); add_packed_codes(129); send_stream();
      add_header(8'h55, fldc_pkg::MAGIC_1, fldc_pkg::VERSION, 8'd2, 16'd1);
      add_code(8'd0, 8'd0, 8'd1); send_stream();
      add_header(fldc_pkg::MAGIC_0, 8'hAF, fldc_pkg::VERSION, 8'd2, 16'd1);
      add_code(8'd0, 8'd0, 8'd1); send_stream();
      add_header(fldc_pkg::MAGIC_0, fldc_pkg::MAGIC_1, 8'hFE, 8'd2, 16'd1);
      add_code(8'd0, 8'd0, 8'd1); send_stream();
      good_header(8'd0, 16'd1); add_code(8'd0, 8'd0, 8'd1); send_stream();
      good_header(8'd65, 16'd1); add_code(8'd0, 8'd0, 8'd1); send_stream();
      good_header(8'd4, 16'd0); send_stream();
      add_noise(1); send_stream();
      good_header(8'd4, 16'd1); void'(stream.pop_back()); send_stream();
      good_header(8'd2, 16'd1); add_code(8'd2, 8'd0, 8'd1); send_stream();
      good_header(8'd2, 16'd1); add_code(8'd0, 8'd0, 8'd0); send_stream();
      good_header(8'd2, 16'd1); add_code(8'd0, 8'd0, 8'd9); send_stream();
      good_header(8'd2, 16'd1); add_code(8'd0, 8'd5, 8'd4); send_stream();
      good_header(8'd64, 16'd1); add_code(8'd64, 8'd0, 8'd1); send_stream();
      good_header(8'd2, 16'd2); add_code(8'd1, 8'd2, 8'd3); add_code(8'd1, 8'd4, 8'd1);
      send_stream();
      good_header(8'd2, 16'd3); add_code(8'd0, 8'd0, 8'd9); add_code(8'd1, 8'd0, 8'd2);
      add_code(8'd1, 8'd1, 8'd2); send_stream();
      good_header(8'd2, 16'd3); add_code(8'd1, 8'd0, 8'd2); add_code(8'd1, 8'd1, 8'd2);
      add_code(8'd0, 8'd0, 8'd9); send_stream();
      good_header(8'd2, 16'd2); add_code(8'd0, 8'd0, 8'd4); add_code(8'd0, 8'd3, 8'd2);
      add_code(8'd1, 8'd0, 8'd1); send_stream();
      good_header(8'd2, 16'd257); add_code(8'd0, 8'd0, 8'd1); send_stream();
      good_header(8'd3, 16'd3); add_code(8'd0, 8'd0, 8'd4); add_code(8'd0, 8'd4, 8'd4);
      add_code(8'd2, 8'd1, 8'd7); send_stream();
      wait_idle();

      // Receiver holds off while short descriptors keep coming, so the block backs up.
      hold_off_go = 1'b1;
      repeat (12) begin
         add_noise($urandom_range(1, 2));
         send_stream();
      end
      wait_idle();

      random_bytes = 0;
      verdicts = 0;
      while (random_bytes < 200 || verdicts < 20) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            unit = (n + 1) / 2 + $urandom_range(0, 4);
            if (unit > fldc_pkg::DEF_MAX_UNIT_BYTES) unit = fldc_pkg::DEF_MAX_UNIT_BYTES;
            good_header(8'(unit), 16'(n));
            add_packed_codes(n);
         end else if (kind < 65) begin
            n = $urandom_range(1, 6);
            unit = $urandom_range(1, 8);
            good_header(8'(unit), 16'(n));
            add_wild_codes(n, unit);
         end else if (kind < 80) begin
            n = $urandom_range(1, 4);
            case ($urandom_range(0, 4))
               0: add_header(8'($urandom), fldc_pkg::MAGIC_1, fldc_pkg::VERSION, 8'd4,
                             16'(n));
               1: add_header(fldc_pkg::MAGIC_0, 8'($urandom), 8'($urandom), 8'd4, 16'(n));
               2: good_header(($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(65, 255)),
                              16'(n));
               3: good_header(8'd4, 16'($urandom_range(129, 65535)));
               default: good_header(8'd4, 16'd0);
            endcase
            add_packed_codes(n);
         end else if (kind < 90) begin
            n = $urandom_range(1, 5);
            good_header(8'd4, 16'(n));
            add_packed_codes(n);
            if ($urandom_range(0, 1) == 0)
               repeat ($urandom_range(1, 2)) void'(stream.pop_back());
            else
               add_noise($urandom_range(1, 4));
         end else begin
            add_noise($urandom_range(1, 8));
         end
         random_bytes += stream.size();
         verdicts++;
         send_stream();
         if ($urandom_range(0, 14) == 0) wait_idle();
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
